// ===== src/x86pop_pkg.sv =====
// ============================================================================
// x86pop_pkg
// Types, codes and helper functions shared by the prefix and opcode parser.
// ============================================================================
`default_nettype none

package x86pop_pkg;

    localparam int MAX_LEGACY_PREFIXES = 4;
    localparam int LEGACY_SLOTS        = 4;
    localparam logic [2:0] LEGACY_LIMIT =
        (MAX_LEGACY_PREFIXES > LEGACY_SLOTS) ? 3'(LEGACY_SLOTS) : 3'(MAX_LEGACY_PREFIXES);

    localparam logic [7:0] BYTE_VEX3   = 8'hC4;
    localparam logic [7:0] BYTE_VEX2   = 8'hC5;
    localparam logic [7:0] BYTE_XOP    = 8'h8F;
    localparam logic [7:0] BYTE_ESC    = 8'h0F;
    localparam logic [7:0] BYTE_ESC_38 = 8'h38;
    localparam logic [7:0] BYTE_ESC_3A = 8'h3A;
    localparam logic [7:0] BYTE_REX_LO = 8'h40;
    localparam logic [7:0] BYTE_REX_HI = 8'h4F;
    localparam logic [4:0] MAP_SEL_MASK = 5'b11111;

    localparam logic [7:0] PFX_LOCK  = 8'hF0;
    localparam logic [7:0] PFX_REPNE = 8'hF2;
    localparam logic [7:0] PFX_REP   = 8'hF3;
    localparam logic [7:0] PFX_CS    = 8'h2E;
    localparam logic [7:0] PFX_SS    = 8'h36;
    localparam logic [7:0] PFX_DS    = 8'h3E;
    localparam logic [7:0] PFX_ES    = 8'h26;
    localparam logic [7:0] PFX_FS    = 8'h64;
    localparam logic [7:0] PFX_GS    = 8'h65;
    localparam logic [7:0] PFX_OPSZ  = 8'h66;
    localparam logic [7:0] PFX_ADSZ  = 8'h67;

    localparam int OUT_TDATA_WIDTH = 80;

    typedef enum logic [2:0] {
        STEP_LEG0 = 3'd0,
        STEP_LEG1 = 3'd1,
        STEP_LEG2 = 3'd2,
        STEP_LEG3 = 3'd3,
        STEP_REX  = 3'd4,
        STEP_ESC1 = 3'd5,
        STEP_ESC2 = 3'd6,
        STEP_OPC  = 3'd7
    } step_t;

    typedef enum logic [1:0] {
        EXT_NONE = 2'd0,
        EXT_VEX2 = 2'd1,
        EXT_VEX3 = 2'd2,
        EXT_XOP  = 2'd3
    } ext_kind_t;

    typedef enum logic [2:0] {
        ESC_NONE = 3'd0,
        ESC_0F   = 3'd1,
        ESC_0F0F = 3'd2,
        ESC_0F38 = 3'd3,
        ESC_0F3A = 3'd4
    } escape_t;

    typedef enum logic [3:0] {
        MAP_PRIMARY = 4'd0,
        MAP_0F      = 4'd1,
        MAP_0F38    = 4'd2,
        MAP_0F3A    = 4'd3,
        MAP_VEX1    = 4'd4,
        MAP_VEX2    = 4'd5,
        MAP_VEX3    = 4'd6,
        MAP_XOP8    = 4'd7,
        MAP_XOP9    = 4'd8,
        MAP_XOPA    = 4'd9,
        MAP_NONE    = 4'd10
    } map_t;

    typedef struct packed {
        step_t       step;
        logic [31:0] prefix_bytes;
        logic [2:0]  prefix_tally;
        logic        rex_seen;
        logic [3:0]  rex_wrxb;
        ext_kind_t   ext_kind;
        logic [7:0]  ext_first;
        logic [7:0]  ext_second;
        escape_t     escape;
        logic [3:0]  byte_tally;
    } parse_state_t;

    localparam parse_state_t STATE_RESET = '{
        step:         STEP_LEG0,
        prefix_bytes: 32'd0,
        prefix_tally: 3'd0,
        rex_seen:     1'b0,
        rex_wrxb:     4'd0,
        ext_kind:     EXT_NONE,
        ext_first:    8'd0,
        ext_second:   8'd0,
        escape:       ESC_NONE,
        byte_tally:   4'd0
    };

    typedef struct packed {
        logic [3:0]  bytes_used;
        logic [7:0]  extension_second;
        logic [7:0]  extension_first;
        logic [1:0]  extension_kind;
        logic [3:0]  rex_wrxb;
        logic        rex_seen;
        logic [2:0]  legacy_prefix_count;
        logic [31:0] legacy_prefix_bytes;
        logic [3:0]  opcode_map;
        logic [7:0]  opcode_value;
    } parse_result_t;

    function automatic logic is_legacy(input logic [7:0] b);
        logic hit;
        hit = (b == PFX_LOCK) || (b == PFX_REPNE) || (b == PFX_REP) ||
              (b == PFX_CS)   || (b == PFX_SS)    || (b == PFX_DS)  ||
              (b == PFX_ES)   || (b == PFX_FS)    || (b == PFX_GS)  ||
              (b == PFX_OPSZ) || (b == PFX_ADSZ);
        return hit;
    endfunction

    function automatic map_t select_map(input parse_state_t st);
        logic [4:0] sel;
        map_t       m;
        sel = st.ext_first[4:0] & MAP_SEL_MASK;
        m   = MAP_NONE;
        case (st.ext_kind)
            EXT_VEX2: m = MAP_VEX1;
            EXT_VEX3:
            begin
                if (sel >= 5'd1 && sel <= 5'd3)
                    m = map_t'(4'(sel[3:0] + 4'd3));
            end
            EXT_XOP:
            begin
                if (sel >= 5'd8 && sel <= 5'd10)
                    m = map_t'(4'(sel[3:0] - 4'd1));
            end
            default:
            begin
                case (st.escape)
                    ESC_NONE: m = MAP_PRIMARY;
                    ESC_0F:   m = MAP_0F;
                    ESC_0F38: m = MAP_0F38;
                    ESC_0F3A: m = MAP_0F3A;
                    default:  m = MAP_NONE;
                endcase
            end
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

// ===== src/x86pop_decode.sv =====
// ============================================================================
// x86pop_decode
// Next-state and result logic for one code byte against the parse state.
// ============================================================================
`default_nettype none

module x86pop_decode
    import x86pop_pkg::*;
(
    input  parse_state_t  cur,
    input  logic [7:0]    code_byte,
    output parse_state_t  nxt,
    output logic          emit,
    output parse_result_t result
);

    logic       legacy_hit;
    logic       at_rex;
    logic       at_esc1;
    logic       at_esc2;
    logic       absorbed;
    logic [3:0] tally_inc;

    always_comb
    begin
        nxt        = cur;
        emit       = 1'b0;
        result     = '0;
        absorbed   = 1'b0;
        at_esc1    = 1'b0;
        at_esc2    = 1'b0;
        tally_inc  = 4'(cur.byte_tally + 4'd1);
        legacy_hit = (cur.step < STEP_REX) && (cur.step < LEGACY_LIMIT) &&
                     is_legacy(code_byte);
        at_rex     = (cur.step <= STEP_REX);

        if (legacy_hit)
        begin
            nxt.prefix_bytes[cur.step[1:0]*8 +: 8] = code_byte;
            nxt.prefix_tally = 3'(cur.prefix_tally + 3'd1);
            nxt.byte_tally   = tally_inc;
            nxt.step         = step_t'(3'(cur.step + 3'd1));
        end
        else
        begin
            if (at_rex)
            begin
                absorbed = 1'b1;
                if (code_byte >= BYTE_REX_LO && code_byte <= BYTE_REX_HI)
                begin
                    nxt.rex_seen = 1'b1;
                    nxt.rex_wrxb = code_byte[3:0];
                end
                else if (code_byte == BYTE_VEX2)
                    nxt.ext_kind = EXT_VEX2;
                else if (code_byte == BYTE_VEX3)
                    nxt.ext_kind = EXT_VEX3;
                else if (code_byte == BYTE_XOP)
                    nxt.ext_kind = EXT_XOP;
                else
                    absorbed = 1'b0;
                if (absorbed)
                begin
                    nxt.step       = STEP_ESC1;
                    nxt.byte_tally = tally_inc;
                end
            end

            at_esc1 = !absorbed && (at_rex || cur.step == STEP_ESC1);
            if (at_esc1)
            begin
                absorbed = 1'b1;
                if (cur.ext_kind == EXT_VEX3 || cur.ext_kind == EXT_XOP)
                begin
                    nxt.ext_first = code_byte;
                    nxt.step      = STEP_ESC2;
                end
                else if (cur.ext_kind == EXT_VEX2)
                begin
                    nxt.ext_first = code_byte;
                    nxt.step      = STEP_OPC;
                end
                else if (code_byte == BYTE_ESC)
                begin
                    nxt.escape = ESC_0F;
                    nxt.step   = STEP_ESC2;
                end
                else
                    absorbed = 1'b0;
                if (absorbed)
                    nxt.byte_tally = tally_inc;
            end

            at_esc2 = !absorbed && !at_esc1 && (cur.step == STEP_ESC2);
            if (at_esc2)
            begin
                absorbed = 1'b1;
                if (cur.ext_kind == EXT_VEX3 || cur.ext_kind == EXT_XOP)
                    nxt.ext_second = code_byte;
                else if (cur.escape == ESC_0F && code_byte == BYTE_ESC)
                    nxt.escape = ESC_0F0F;
                else if (cur.escape == ESC_0F && code_byte == BYTE_ESC_38)
                    nxt.escape = ESC_0F38;
                else if (cur.escape == ESC_0F && code_byte == BYTE_ESC_3A)
                    nxt.escape = ESC_0F3A;
                else
                    absorbed = 1'b0;
                if (absorbed)
                begin
                    nxt.step       = STEP_OPC;
                    nxt.byte_tally = tally_inc;
                end
            end

            if (!absorbed)
            begin
                emit                       = 1'b1;
                result.opcode_value        = code_byte;
                result.opcode_map          = select_map(cur);
                result.legacy_prefix_bytes = cur.prefix_bytes;
                result.legacy_prefix_count = cur.prefix_tally;
                result.rex_seen            = cur.rex_seen;
                result.rex_wrxb            = cur.rex_wrxb;
                result.extension_kind      = cur.ext_kind;
                result.extension_first     = cur.ext_first;
                result.extension_second    = cur.ext_second;
                result.bytes_used          = tally_inc;
                nxt                        = STATE_RESET;
            end
        end
    end

endmodule

`default_nettype wire

// ===== src/x86_prefix_opcode_parser_core.sv =====
// ============================================================================
// x86_prefix_opcode_parser_core
// Byte-serial x86-64 legacy prefix, REX/VEX/XOP, escape and opcode parser.
// ============================================================================
// Code bytes enter one word per cycle through an input register. Each byte
// is resolved combinationally against the parse state, and the parse state
// is updated at the edge that consumes it, so a byte can be accepted on every clock while
// the output side is ready. Prefix, payload and escape bytes produce no output
// word. The opcode byte produces one output word, which is written to the output
// register when the byte leaves the input register. While an output word waits,
// the input register holds its byte and the input side stalls.
`default_nettype none

module x86_prefix_opcode_parser_core
    import x86pop_pkg::*;
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       s_axis_tvalid,
    output logic                            s_axis_tready,
    // code_byte [7:0]
    input  wire logic [7:0]                 s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  wire logic                       m_axis_tready,
    // opcode_value [7:0], opcode_map [11:8], legacy_prefix_bytes [43:12],
    // legacy_prefix_count [46:44], rex_seen [47], rex_wrxb [51:48],
    // extension_kind [53:52], extension_first [61:54],
    // extension_second [69:62], bytes_used [73:70], zero padding [79:74]
    output logic [OUT_TDATA_WIDTH-1:0]      m_axis_tdata
);

    logic          in_valid_reg;
    logic          in_valid_next;
    logic [7:0]    in_byte_reg;
    logic          out_valid_reg;
    logic          out_valid_next;
    parse_result_t out_data_reg;
    parse_state_t  state_reg;
    parse_state_t  state_next;
    parse_result_t result;
    logic          emit;
    logic          advance;
    logic          in_accept;

    x86pop_decode u_decode (
        .cur       (state_reg),
        .code_byte (in_byte_reg),
        .nxt       (state_next),
        .emit      (emit),
        .result    (result)
    );

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_accept)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (advance && emit)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= STATE_RESET;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
                state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
            in_byte_reg <= s_axis_tdata;
        if (advance && emit)
            out_data_reg <= result;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_TDATA_WIDTH - $bits(parse_result_t)){1'b0}}, out_data_reg};

endmodule

`default_nettype wire

// ===== src/x86pop_checker.sv =====
// ============================================================================
// x86pop_checker
// Port-level checks on the output words of the prefix and opcode parser.
// ============================================================================
`default_nettype none

module x86pop_checker
    import x86pop_pkg::*;
(
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        m_axis_tvalid,
    input wire logic                        m_axis_tready,
    input wire logic [OUT_TDATA_WIDTH-1:0]  m_axis_tdata
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("Output word changed or vanished while stalled.");

    a_bytes_used: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[73:70] != 4'd0 && m_axis_tdata[73:70] <= 4'd8 &&
                          m_axis_tdata[73:70] > {1'b0, m_axis_tdata[46:44]})
        else $error("Byte count inconsistent with the prefix count.");

    a_map_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[11:8] <= MAP_NONE && m_axis_tdata[46:44] <= 3'd4 &&
                          m_axis_tdata[79:74] == 6'd0)
        else $error("Map code, prefix count or padding out of range.");

    a_ext_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[53:52] == EXT_NONE |->
            m_axis_tdata[61:54] == 8'd0 && m_axis_tdata[69:62] == 8'd0 &&
            (m_axis_tdata[47] || m_axis_tdata[51:48] == 4'd0))
        else $error("Extension or REX fields set without their prefix.");

    a_rex_excl: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[47] |-> m_axis_tdata[53:52] == EXT_NONE)
        else $error("REX and VEX/XOP reported together.");

endmodule

bind x86_prefix_opcode_parser_core x86pop_checker u_x86pop_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// ============================================================================
// testbench
// Self-checking bench for the x86 prefix and opcode parser core. A directed
// table opens the run: extreme bytes, the prefix limit, late prefixes,
// escapes, and VEX/XOP words with maps that are not supported. Random
// instructions with random content, noise bytes and truncated sequences
// follow. Every opcode word is checked field by field against its table row
// or a decoder model kept in the bench; both sides stall at random before the last bytes.
// ============================================================================

module testbench;
    import x86pop_pkg::*;

    localparam int IDLE_LIMIT   = 1000;
    localparam int RANDOM_BYTES = 400;
    localparam int CALM_BYTES   = 60;
    localparam int DRAIN_CYCLES = 8;
    localparam int RESULT_BITS  = $bits(parse_result_t);

    typedef struct packed {
        step_t           stage;
        logic [3:0][7:0] prefixes;
        logic [2:0]      prefix_count;
        logic            rex_hit;
        logic [3:0]      wrxb;
        ext_kind_t       ext;
        logic [7:0]      payload0;
        logic [7:0]      payload1;
        escape_t         esc;
        logic [3:0]      consumed;
    } decode_track_t;

    typedef struct packed {
        logic [7:0] code;
        logic       typed;
        map_t       map;
        ext_kind_t  ext;
        logic [7:0] first;
        logic [7:0] second;
        logic [3:0] used;
    } directed_row_t;

    logic                       clk = 1'b0;
    logic                       rst_n;
    logic                       s_axis_tvalid;
    logic                       s_axis_tready;
    logic [7:0]                 s_axis_tdata;
    logic                       m_axis_tvalid;
    logic                       m_axis_tready;
    logic [OUT_TDATA_WIDTH-1:0] m_axis_tdata;

    decode_track_t  track;
    parse_result_t  pending_opcodes [$];
    parse_result_t  got_word;
    parse_result_t  want_word;
    int             mismatches;
    int             bytes_sent;
    int             words_checked;
    int             idle_cycles;
    int             stall_left;
    logic           calm;
    logic [15:0]    maps_seen;

    logic [7:0] legacy_codes [0:10] = '{PFX_LOCK, PFX_REPNE, PFX_REP, PFX_CS, PFX_SS,
                                        PFX_DS, PFX_ES, PFX_FS, PFX_GS, PFX_OPSZ,
                                        PFX_ADSZ};

    directed_row_t directed_rows [0:25] = '{
        '{8'hFF, 1'b1, MAP_PRIMARY, EXT_NONE, 8'h00, 8'h00, 4'd1},
        '{PFX_OPSZ, 1'b0, MAP_PRIMARY, EXT_NONE, 8'h00, 8'h00, 4'd0},
        '{PFX_REP, 1'b0, MAP_PRIMARY, EXT_NONE, 8'h00, 8'h00, 4'd0},
        '{PFX_CS, 1'b0, MAP_PRIMARY, EXT_NONE, 8'h00, 8'h00, 4'd0},
        '{PFX_ADSZ, 1'b0, MAP_PRIMARY, EXT_NONE, 8'h00, 8'h00, 4'd0},
        '{PFX_LOCK, 1'b0, MAP_PRIMARY, EXT_NONE, 8'h00, 8'h00, 4'd0},
        '{8'h48, 1'b0, MAP_PRIMARY, EXT_NONE, 8'h00, 8'h00, 4'd0},
        '{BYTE_ESC, 1'b0, MAP_PRIMARY, EXT_NONE, 8'h00, 8'h00, 4'd0},
        '{BYTE_ESC_38, 1'b0, MAP_PRIMARY, EXT_NONE, 8'h00, 8'h00, 4'd0},
        '{8'h00, 1'b0, MAP_PRIMARY, EXT_NONE, 8'h00, 8'h00, 4'd0},
        '{BYTE_ESC, 1'b0, MAP_PRIMARY, EXT_NONE, 8'h00, 8'h00, 4'd0},
        '{BYTE_ESC, 1'b0, MAP_PRIMARY, EXT_NONE, 8'h00, 8'h00, 4'd0},
        '{8'h90, 1'b1, MAP_NONE, EXT_NONE, 8'h00, 8'h00, 4'd3},
        '{BYTE_VEX2, 1'b0, MAP_PRIMARY, EXT_NONE, 8'h00, 8'h00, 4'd0},
        '{8'hF8, 1'b0, MAP_PRIMARY, EXT_NONE, 8'h00, 8'h00, 4'd0},
        '{8'h77, 1'b0, MAP_PRIMARY, EXT_NONE, 8'h00, 8'h00, 4'd0},
        '{BYTE_VEX3, 1'b0, MAP_PRIMARY, EXT_NONE, 8'h00, 8'h00, 4'd0},
        '{8'hFF, 1'b0, MAP_PRIMARY, EXT_NONE, 8'h00, 8'h00, 4'd0},
        '{8'hFF, 1'b0, MAP_PRIMARY, EXT_NONE, 8'h00, 8'h00, 4'd0},
        '{8'h00, 1'b1, MAP_NONE, EXT_VEX3, 8'hFF, 8'hFF, 4'd4},
        '{BYTE_XOP, 1'b0, MAP_PRIMARY, EXT_NONE, 8'h00, 8'h00, 4'd0},
        '{8'h00, 1'b0, MAP_PRIMARY, EXT_NONE, 8'h00, 8'h00, 4'd0},
        '{8'h00, 1'b0, MAP_PRIMARY, EXT_NONE, 8'h00, 8'h00, 4'd0},
        '{8'h00, 1'b1, MAP_NONE, EXT_XOP, 8'h00, 8'h00, 4'd4},
        '{8'h41, 1'b0, MAP_PRIMARY, EXT_NONE, 8'h00, 8'h00, 4'd0},
        '{BYTE_VEX2, 1'b0, MAP_PRIMARY, EXT_NONE, 8'h00, 8'h00, 4'd0}
    };

    x86_prefix_opcode_parser_core DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 clk = ~clk;

    function automatic logic is_legacy_code(input logic [7:0] code);
        logic hit;
        hit = 1'b0;
        foreach (legacy_codes[k])
            if (legacy_codes[k] == code)
                hit = 1'b1;
        return hit;
    endfunction

    function automatic map_t opcode_map_of(input decode_track_t t);
        logic [4:0] sel;
        map_t       m;
        sel = t.payload0[4:0];
        m   = MAP_NONE;
        case (t.ext)
            EXT_VEX2: m = MAP_VEX1;
            EXT_VEX3:
            begin
                case (sel)
                    5'd1: m = MAP_VEX1;
                    5'd2: m = MAP_VEX2;
                    5'd3: m = MAP_VEX3;
                    default: m = MAP_NONE;
                endcase
            end
            EXT_XOP:
            begin
                case (sel)
                    5'd8:  m = MAP_XOP8;
                    5'd9:  m = MAP_XOP9;
                    5'd10: m = MAP_XOPA;
                    default: m = MAP_NONE;
                endcase
            end
            default:
            begin
                case (t.esc)
                    ESC_NONE: m = MAP_PRIMARY;
                    ESC_0F:   m = MAP_0F;
                    ESC_0F38: m = MAP_0F38;
                    ESC_0F3A: m = MAP_0F3A;
                    default:  m = MAP_NONE;
                endcase
            end
        endcase
        return m;
    endfunction

    // A byte that a stage does not take falls through to the next stage, so the
    // stages are tried in order until one absorbs the byte or the opcode ends it.
    task automatic decode_byte(input logic [7:0] code, output logic emits,
                               output parse_result_t word);
        logic took;
        emits = 1'b0;
        word  = '0;
        if (track.stage <= STEP_LEG3)
        begin
            if (int'(track.stage) < MAX_LEGACY_PREFIXES && is_legacy_code(code))
            begin
                track.prefixes[int'(track.stage)] = code;
                track.prefix_count = track.prefix_count + 3'd1;
                track.consumed     = track.consumed + 4'd1;
                track.stage        = step_t'(track.stage + 3'd1);
                return;
            end
            track.stage = STEP_REX;
        end
        if (track.stage == STEP_REX)
        begin
            track.stage = STEP_ESC1;
            took = 1'b1;
            if (code >= BYTE_REX_LO && code <= BYTE_REX_HI)
            begin
                track.rex_hit = 1'b1;
                track.wrxb    = code[3:0];
            end
            else if (code == BYTE_VEX2)
                track.ext = EXT_VEX2;
            else if (code == BYTE_VEX3)
                track.ext = EXT_VEX3;
            else if (code == BYTE_XOP)
                track.ext = EXT_XOP;
            else
                took = 1'b0;
            if (took)
            begin
                track.consumed = track.consumed + 4'd1;
                return;
            end
        end
        if (track.stage == STEP_ESC1)
        begin
            took = 1'b1;
            if (track.ext == EXT_VEX3 || track.ext == EXT_XOP)
            begin
                track.payload0 = code;
                track.stage    = STEP_ESC2;
            end
            else if (track.ext == EXT_VEX2)
            begin
                track.payload0 = code;
                track.stage    = STEP_OPC;
            end
            else if (code == BYTE_ESC)
            begin
                track.esc   = ESC_0F;
                track.stage = STEP_ESC2;
            end
            else
            begin
                track.stage = STEP_OPC;
                took = 1'b0;
            end
            if (took)
            begin
                track.consumed = track.consumed + 4'd1;
                return;
            end
        end
        if (track.stage == STEP_ESC2)
        begin
            track.stage = STEP_OPC;
            took = 1'b1;
            if (track.ext == EXT_VEX3 || track.ext == EXT_XOP)
                track.payload1 = code;
            else if (track.esc == ESC_0F && code == BYTE_ESC)
                track.esc = ESC_0F0F;
            else if (track.esc == ESC_0F && code == BYTE_ESC_38)
                track.esc = ESC_0F38;
            else if (track.esc == ESC_0F && code == BYTE_ESC_3A)
                track.esc = ESC_0F3A;
            else
                took = 1'b0;
            if (took)
            begin
                track.consumed = track.consumed + 4'd1;
                return;
            end
        end
        emits = 1'b1;
        word.opcode_value        = code;
        word.opcode_map          = opcode_map_of(track);
        word.legacy_prefix_bytes = track.prefixes;
        word.legacy_prefix_count = track.prefix_count;
        word.rex_seen            = track.rex_hit;
        word.rex_wrxb            = track.wrxb;
        word.extension_kind      = track.ext;
        word.extension_first     = track.payload0;
        word.extension_second    = track.payload1;
        word.bytes_used          = track.consumed + 4'd1;
        track = '0;
    endtask

    task automatic send_code(input logic [7:0] code, input logic typed,
                             input parse_result_t typed_word);
        logic          emits;
        parse_result_t word;
        s_axis_tdata  <= code;
        s_axis_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        decode_byte(code, emits, word);
        if (emits)
            pending_opcodes.push_back(typed ? typed_word : word);
        bytes_sent++;
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
    endtask

    task automatic send_instruction();
        logic [7:0] seq [$];
        int         n_prefixes;
        int         shape;
        logic [4:0] sel;
        if ($urandom_range(0, 9) == 0)
        begin
            repeat ($urandom_range(1, 4)) seq.push_back(8'($urandom));
        end
        else
        begin
            n_prefixes = $urandom_range(0, 4);
            if ($urandom_range(0, 11) == 0)
                n_prefixes = 5;
            repeat (n_prefixes) seq.push_back(legacy_codes[$urandom_range(0, 10)]);
            shape = $urandom_range(0, 5);
            case (shape)
                1: seq.push_back(BYTE_REX_LO | 8'($urandom_range(0, 15)));
                2:
                begin
                    seq.push_back(BYTE_VEX2);
                    seq.push_back(8'($urandom));
                end
                3, 4:
                begin
                    sel = (shape == 3) ? 5'($urandom_range(1, 3)) : 5'($urandom_range(8, 10));
                    if ($urandom_range(0, 4) == 0)
                        sel = 5'($urandom);
                    seq.push_back((shape == 3) ? BYTE_VEX3 : BYTE_XOP);
                    seq.push_back({3'($urandom), sel});
                    seq.push_back(8'($urandom));
                end
                default: ;
            endcase
            if (shape <= 1 || shape == 5)
            begin
                case ($urandom_range(0, 4))
                    1: seq.push_back(BYTE_ESC);
                    2:
                    begin
                        seq.push_back(BYTE_ESC);
                        seq.push_back(BYTE_ESC_38);
                    end
                    3:
                    begin
                        seq.push_back(BYTE_ESC);
                        seq.push_back(BYTE_ESC_3A);
                    end
                    4:
                    begin
                        seq.push_back(BYTE_ESC);
                        seq.push_back(BYTE_ESC);
                    end
                    default: ;
                endcase
            end
            seq.push_back(8'($urandom));
            // A truncated instruction runs on into the next one.
            if ($urandom_range(0, 15) == 0)
                void'(seq.pop_back());
        end
        foreach (seq[k])
            send_code(seq[k], 1'b0, '0);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end
        else if (!calm && $urandom_range(0, 7) == 0)
        begin
            stall_left = $urandom_range(1, 19) - 1;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got_word = parse_result_t'(m_axis_tdata[RESULT_BITS-1:0]);
            if (pending_opcodes.size() == 0)
            begin
                $display("%0t: unexpected word: expected none, actual %h", $time, m_axis_tdata);
                mismatches++;
            end
            else
            begin
                want_word = pending_opcodes.pop_front();
                check_field("opcode_value", want_word.opcode_value, got_word.opcode_value);
                check_field("opcode_map", want_word.opcode_map, got_word.opcode_map);
                check_field("legacy_prefix_bytes", want_word.legacy_prefix_bytes,
                            got_word.legacy_prefix_bytes);
                check_field("legacy_prefix_count", want_word.legacy_prefix_count,
                            got_word.legacy_prefix_count);
                check_field("rex_seen", want_word.rex_seen, got_word.rex_seen);
                check_field("rex_wrxb", want_word.rex_wrxb, got_word.rex_wrxb);
                check_field("extension_kind", want_word.extension_kind,
                            got_word.extension_kind);
                check_field("extension_first", want_word.extension_first,
                            got_word.extension_first);
                check_field("extension_second", want_word.extension_second,
                            got_word.extension_second);
                check_field("bytes_used", want_word.bytes_used, got_word.bytes_used);
                check_field("padding", '0, 32'(m_axis_tdata[OUT_TDATA_WIDTH-1:RESULT_BITS]));
                maps_seen[got_word.opcode_map] = 1'b1;
                words_checked++;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%0t: no word moved for %0d cycles, %0d words outstanding",
                         $time, IDLE_LIMIT, pending_opcodes.size());
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        parse_result_t typed_word;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'h00;
        m_axis_tready = 1'b0;
        track         = '0;
        mismatches    = 0;
        bytes_sent    = 0;
        words_checked = 0;
        idle_cycles   = 0;
        stall_left    = 0;
        calm          = 1'b0;
        maps_seen     = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            typed_word                  = '0;
            typed_word.opcode_value     = directed_rows[i].code;
            typed_word.opcode_map       = directed_rows[i].map;
            typed_word.extension_kind   = directed_rows[i].ext;
            typed_word.extension_first  = directed_rows[i].first;
            typed_word.extension_second = directed_rows[i].second;
            typed_word.bytes_used       = directed_rows[i].used;
            send_code(directed_rows[i].code, directed_rows[i].typed, typed_word);
        end

        // The sender holds off here until the output side has drained.
        s_axis_tvalid <= 1'b0;
        while (pending_opcodes.size() != 0)
            @(posedge clk);
        @(posedge clk);

        while (bytes_sent < $size(directed_rows) + RANDOM_BYTES)
        begin
            if (bytes_sent >= $size(directed_rows) + RANDOM_BYTES - CALM_BYTES)
                calm = 1'b1;
            send_instruction();
        end

        s_axis_tvalid <= 1'b0;
        while (pending_opcodes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d code bytes and checked %0d opcode words under random stalls.",
                 bytes_sent, words_checked);
        $display("Opcode maps observed: %0d of 11.", $countones(maps_seen));
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
src/x86pop_pkg.sv
src/x86pop_decode.sv
src/x86_prefix_opcode_parser_core.sv
src/x86pop_checker.sv
bench/testbench.sv
